// ===== hw/rtl/spfa_pkg.sv =====
// ----------------------------------------------------------------------------
// SPFA shortest path package
// Shared types and constants of the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spfa_pkg;

  localparam int unsigned COST_W  = 32;
  localparam int unsigned CNT_W   = 11;
  localparam logic [CNT_W-1:0] TALLY_MAX = 11'd2047;
  localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_SOLVE = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_CLR_HEAD,
    ST_INIT,
    ST_SEED,
    ST_POP,
    ST_NODE_RD,
    ST_POP_UPD,
    ST_EDGE_RD,
    ST_DEST_RD,
    ST_RELAX,
    ST_TGT_RD,
    ST_RESULT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_HEAD_RD,
    OP_ADD_WR,
    OP_CLR_HEAD,
    OP_CLR_NODE,
    OP_SEED,
    OP_POP_RD,
    OP_NODE_RD,
    OP_POP_UPD,
    OP_SET_NEG,
    OP_EDGE_RD,
    OP_DEST_RD,
    OP_RELAX,
    OP_TGT_RD,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    logic   accept;
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_func;
    logic       in_ok;
    logic       sweep_last;
    logic       used_zero;
    logic       p_zero;
    logic       tally_hit;
    logic       out_free;
  } sts_t;

  typedef struct packed {
    logic                     reached;
    logic                     queued;
    logic [CNT_W-1:0]         tally;
    logic signed [COST_W-1:0] best;
  } node_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spfa_if.sv =====
// ----------------------------------------------------------------------------
// SPFA channel interfaces
// Request, response and configuration channels with valid and ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spfa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [9:0]  from_node;
  logic [9:0]  to_node;
  logic signed [31:0] weight;
  logic [9:0]  source_node;
  logic [9:0]  target_node;
  modport source (output valid, func, from_node, to_node, weight, source_node,
                  target_node, input ready);
  modport sink (input valid, func, from_node, to_node, weight, source_node,
                target_node, output ready);
endinterface

interface spfa_rsp_if;
  logic        valid;
  logic        ready;
  logic        negative_cycle;
  logic        unreachable;
  logic signed [31:0] distance;
  modport source (output valid, negative_cycle, unreachable, distance, input ready);
  modport sink (input valid, negative_cycle, unreachable, distance, output ready);
endinterface

interface spfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/spfa_shortest_path_negcycle.sv =====
// ----------------------------------------------------------------------------
// SPFA shortest path with negative-cycle detection
// Graph store and queue-based Bellman-Ford solver behind valid/ready channels.
// ----------------------------------------------------------------------------
// An edge load reads the list head of its source node and then writes the edge;
// a graph clear sweeps every list head, and the same sweep also runs after
// reset. A solve accepts, initializes the node store and seeds the queue, then
// dequeues nodes and relaxes their edges one at a time, and then reports; a
// solve with an out-of-range node goes straight to the report. The block
// accepts the next request while a response waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module spfa_shortest_path_negcycle #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 8192
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spfa_req_if.sink   req_i,
  spfa_rsp_if.source rsp_o,
  spfa_cfg_if.sink   cfg_i
);

  spfa_pkg::cmd_t cmd;
  spfa_pkg::sts_t sts;

  assign req_i.ready = cmd.accept;
  assign cfg_i.ready = 1'b1;

  spfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spfa_dpath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (req_i.valid),
    .func_i           (req_i.func),
    .from_node_i      (req_i.from_node),
    .to_node_i        (req_i.to_node),
    .weight_i         (req_i.weight),
    .source_node_i    (req_i.source_node),
    .target_node_i    (req_i.target_node),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_data_i       (cfg_i.data),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_valid_o      (rsp_o.valid),
    .negative_cycle_o (rsp_o.negative_cycle),
    .unreachable_o    (rsp_o.unreachable),
    .distance_o       (rsp_o.distance),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/spfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// SPFA controller
// State machine that sequences edge loads, graph clears and solves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spfa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  input  spfa_pkg::sts_t     sts_i,
  output spfa_pkg::cmd_t     cmd_o
);

  spfa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spfa_pkg::ST_CLR_HEAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o.accept = 1'b0;
    cmd_o.op = spfa_pkg::OP_NONE;
    unique case (state_q)
      spfa_pkg::ST_IDLE: begin
        cmd_o.accept = 1'b1;
        if (req_valid_i) begin
          case (sts_i.in_func)
            spfa_pkg::FUNC_ADD:   state_d = sts_i.in_ok ? spfa_pkg::ST_ADD_RD
                                                        : spfa_pkg::ST_IDLE;
            spfa_pkg::FUNC_CLEAR: state_d = spfa_pkg::ST_CLR_HEAD;
            spfa_pkg::FUNC_SOLVE: state_d = sts_i.in_ok ? spfa_pkg::ST_INIT
                                                        : spfa_pkg::ST_TGT_RD;
            default:              state_d = spfa_pkg::ST_IDLE;
          endcase
        end
      end
      spfa_pkg::ST_ADD_RD: begin
        cmd_o.op = spfa_pkg::OP_HEAD_RD;
        state_d = spfa_pkg::ST_ADD_WR;
      end
      spfa_pkg::ST_ADD_WR: begin
        cmd_o.op = spfa_pkg::OP_ADD_WR;
        state_d = spfa_pkg::ST_IDLE;
      end
      spfa_pkg::ST_CLR_HEAD: begin
        cmd_o.op = spfa_pkg::OP_CLR_HEAD;
        if (sts_i.sweep_last) state_d = spfa_pkg::ST_IDLE;
      end
      spfa_pkg::ST_INIT: begin
        cmd_o.op = spfa_pkg::OP_CLR_NODE;
        if (sts_i.sweep_last) state_d = spfa_pkg::ST_SEED;
      end
      spfa_pkg::ST_SEED: begin
        cmd_o.op = spfa_pkg::OP_SEED;
        state_d = spfa_pkg::ST_POP;
      end
      spfa_pkg::ST_POP: begin
        if (sts_i.used_zero) begin
          state_d = spfa_pkg::ST_TGT_RD;
        end else begin
          cmd_o.op = spfa_pkg::OP_POP_RD;
          state_d = spfa_pkg::ST_NODE_RD;
        end
      end
      spfa_pkg::ST_NODE_RD: begin
        cmd_o.op = spfa_pkg::OP_NODE_RD;
        state_d = spfa_pkg::ST_POP_UPD;
      end
      spfa_pkg::ST_POP_UPD: begin
        if (sts_i.tally_hit) begin
          cmd_o.op = spfa_pkg::OP_SET_NEG;
          state_d = spfa_pkg::ST_TGT_RD;
        end else begin
          cmd_o.op = spfa_pkg::OP_POP_UPD;
          state_d = spfa_pkg::ST_EDGE_RD;
        end
      end
      spfa_pkg::ST_EDGE_RD: begin
        if (sts_i.p_zero) begin
          state_d = spfa_pkg::ST_POP;
        end else begin
          cmd_o.op = spfa_pkg::OP_EDGE_RD;
          state_d = spfa_pkg::ST_DEST_RD;
        end
      end
      spfa_pkg::ST_DEST_RD: begin
        cmd_o.op = spfa_pkg::OP_DEST_RD;
        state_d = spfa_pkg::ST_RELAX;
      end
      spfa_pkg::ST_RELAX: begin
        cmd_o.op = spfa_pkg::OP_RELAX;
        state_d = spfa_pkg::ST_EDGE_RD;
      end
      spfa_pkg::ST_TGT_RD: begin
        cmd_o.op = spfa_pkg::OP_TGT_RD;
        state_d = spfa_pkg::ST_RESULT;
      end
      spfa_pkg::ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.op = spfa_pkg::OP_RESULT;
          state_d = spfa_pkg::ST_IDLE;
        end
      end
      default: state_d = spfa_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spfa_dpath.sv =====
// ----------------------------------------------------------------------------
// SPFA datapath
// Edge store, node store, work queue, counters and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spfa_dpath #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 8192
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  input  wire logic [1:0]         func_i,
  input  wire logic [9:0]         from_node_i,
  input  wire logic [9:0]         to_node_i,
  input  wire logic signed [31:0] weight_i,
  input  wire logic [9:0]         source_node_i,
  input  wire logic [9:0]         target_node_i,
  input  wire logic               cfg_valid_i,
  input  wire logic [10:0]        cfg_data_i,
  input  wire logic               rsp_ready_i,
  output logic                    rsp_valid_o,
  output logic                    negative_cycle_o,
  output logic                    unreachable_o,
  output logic signed [31:0]      distance_o,
  input  spfa_pkg::cmd_t          cmd_i,
  output spfa_pkg::sts_t          sts_o
);

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned UW = $clog2(MAX_NODES + 1);
  localparam int unsigned KW = $clog2(MAX_EDGES);
  localparam int unsigned EW = $clog2(MAX_EDGES + 1);
  localparam logic [31:0] NODE_LIM = 32'(MAX_NODES);
  localparam logic [NW-1:0] NODE_LAST = NW'(MAX_NODES - 1);
  localparam logic [UW-1:0] USED_LIM = UW'(MAX_NODES);
  localparam logic [EW-1:0] EDGE_LIM = EW'(MAX_EDGES);

  logic [NW-1:0]                edge_dest [MAX_EDGES];
  logic [EW-1:0]                edge_link [MAX_EDGES];
  logic signed [31:0]           edge_cost [MAX_EDGES];
  logic [EW-1:0]                list_head [MAX_NODES];
  spfa_pkg::node_t              node_mem  [MAX_NODES];
  logic [NW-1:0]                work_ring [MAX_NODES];

  logic [NW-1:0] from_q, to_q, src_q, tgt_q, u_q, v_q, sweep_q, rd_q, wr_q;
  logic signed [31:0] weight_q, du_q;
  logic [EW-1:0] total_q, p_q;
  logic [UW-1:0] used_q;
  logic [10:0]   node_count_q;
  logic          bad_q, neg_q;

  logic [NW-1:0]      dest_rd, ring_rd;
  logic [EW-1:0]      link_rd, head_rd;
  logic signed [31:0] cost_rd;
  spfa_pkg::node_t    node_rd;

  logic          add_ok, solve_ok;
  logic [10:0]   limit, tally;
  logic [32:0]   sum;
  logic signed [31:0] nd;
  logic          relax_hit, push;
  logic [KW-1:0] p_slot;

  assign add_ok = ({22'd0, from_node_i} < NODE_LIM) && ({22'd0, to_node_i} < NODE_LIM)
                  && (total_q < EDGE_LIM);
  assign solve_ok = ({22'd0, source_node_i} < NODE_LIM)
                    && ({22'd0, target_node_i} < NODE_LIM);

  assign limit = (node_count_q == 11'd0) ? 11'd1 : node_count_q;
  assign tally = (node_rd.tally == spfa_pkg::TALLY_MAX) ? node_rd.tally
                                                        : node_rd.tally + 11'd1;
  assign sum = {du_q[31], du_q} + {cost_rd[31], cost_rd};
  assign nd = (sum[32] != sum[31]) ? (sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                                   : $signed(sum[31:0]);
  assign relax_hit = !node_rd.reached || (nd < node_rd.best);
  assign push = relax_hit && !node_rd.queued && (used_q < USED_LIM);
  assign p_slot = KW'(p_q - EW'(1));

  assign sts_o.in_func    = func_i;
  assign sts_o.in_ok      = (func_i == spfa_pkg::FUNC_ADD) ? add_ok : solve_ok;
  assign sts_o.sweep_last = (sweep_q == NODE_LAST);
  assign sts_o.used_zero  = (used_q == '0);
  assign sts_o.p_zero     = (p_q == '0);
  assign sts_o.tally_hit  = (tally == limit);
  assign sts_o.out_free   = !rsp_valid_o || rsp_ready_i;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      spfa_pkg::OP_HEAD_RD: head_rd <= list_head[from_q];
      spfa_pkg::OP_NODE_RD: begin
        node_rd <= node_mem[ring_rd];
        head_rd <= list_head[ring_rd];
      end
      spfa_pkg::OP_POP_RD:  ring_rd <= work_ring[rd_q];
      spfa_pkg::OP_EDGE_RD: begin
        dest_rd <= edge_dest[p_slot];
        link_rd <= edge_link[p_slot];
        cost_rd <= edge_cost[p_slot];
      end
      spfa_pkg::OP_DEST_RD: node_rd <= node_mem[dest_rd];
      spfa_pkg::OP_TGT_RD:  node_rd <= node_mem[tgt_q];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      spfa_pkg::OP_ADD_WR: begin
        edge_dest[total_q[KW-1:0]] <= to_q;
        edge_cost[total_q[KW-1:0]] <= weight_q;
        edge_link[total_q[KW-1:0]] <= head_rd;
        list_head[from_q] <= total_q + EW'(1);
      end
      spfa_pkg::OP_CLR_HEAD: list_head[sweep_q] <= '0;
      spfa_pkg::OP_CLR_NODE: node_mem[sweep_q] <= '0;
      spfa_pkg::OP_SEED: begin
        node_mem[src_q] <= '{reached: 1'b1, queued: 1'b1, tally: '0, best: '0};
        work_ring[NW'(0)] <= src_q;
      end
      spfa_pkg::OP_POP_UPD: begin
        node_mem[u_q] <= '{reached: node_rd.reached, queued: 1'b0, tally: tally,
                           best: node_rd.best};
      end
      spfa_pkg::OP_RELAX: begin
        if (relax_hit) begin
          node_mem[v_q] <= '{reached: 1'b1, queued: node_rd.queued | push,
                             tally: node_rd.tally, best: nd};
        end
        if (push) work_ring[wr_q] <= v_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && req_valid_i) begin
      from_q   <= NW'(from_node_i);
      to_q     <= NW'(to_node_i);
      weight_q <= weight_i;
      src_q    <= NW'(source_node_i);
      tgt_q    <= NW'(target_node_i);
    end
    if (cmd_i.op == spfa_pkg::OP_NODE_RD) u_q <= ring_rd;
    if (cmd_i.op == spfa_pkg::OP_DEST_RD) v_q <= dest_rd;
    if (cmd_i.op == spfa_pkg::OP_POP_UPD) du_q <= node_rd.best;
    if (cmd_i.op == spfa_pkg::OP_RELAX && relax_hit && v_q == u_q) du_q <= nd;
    if (cmd_i.op == spfa_pkg::OP_RESULT) begin
      negative_cycle_o <= neg_q && !bad_q;
      unreachable_o    <= !neg_q && (bad_q || !node_rd.reached);
      distance_o       <= (neg_q || bad_q || !node_rd.reached) ? 32'sd0 : node_rd.best;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= '0;
      sweep_q      <= '0;
      rd_q         <= '0;
      wr_q         <= '0;
      used_q       <= '0;
      p_q          <= '0;
      bad_q        <= 1'b0;
      neg_q        <= 1'b0;
      rsp_valid_o  <= 1'b0;
      node_count_q <= spfa_pkg::NODE_COUNT_RESET;
    end else begin
      if (cfg_valid_i) node_count_q <= cfg_data_i;
      if (cmd_i.accept && req_valid_i) begin
        bad_q <= !solve_ok;
        neg_q <= 1'b0;
      end
      if (rsp_valid_o && rsp_ready_i) rsp_valid_o <= 1'b0;
      case (cmd_i.op)
        spfa_pkg::OP_ADD_WR: total_q <= total_q + EW'(1);
        spfa_pkg::OP_CLR_HEAD, spfa_pkg::OP_CLR_NODE: begin
          sweep_q <= (sweep_q == NODE_LAST) ? '0 : sweep_q + NW'(1);
          if (cmd_i.op == spfa_pkg::OP_CLR_HEAD) total_q <= '0;
        end
        spfa_pkg::OP_SEED: begin
          rd_q   <= '0;
          wr_q   <= NW'(1);
          used_q <= UW'(1);
        end
        spfa_pkg::OP_POP_RD: begin
          rd_q   <= (rd_q == NODE_LAST) ? '0 : rd_q + NW'(1);
          used_q <= used_q - UW'(1);
        end
        spfa_pkg::OP_POP_UPD: p_q <= head_rd;
        spfa_pkg::OP_SET_NEG: neg_q <= 1'b1;
        spfa_pkg::OP_RELAX: begin
          p_q <= link_rd;
          if (push) begin
            wr_q   <= (wr_q == NODE_LAST) ? '0 : wr_q + NW'(1);
            used_q <= used_q + UW'(1);
          end
        end
        spfa_pkg::OP_RESULT: rsp_valid_o <= 1'b1;
        default: ;
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= USED_LIM) else $error("work queue count above capacity");
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= EDGE_LIM) else $error("edge count above capacity");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == spfa_pkg::OP_POP_RD |-> used_q != '0)
    else $error("dequeue from an empty work queue");
  a_result_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == spfa_pkg::OP_RESULT |-> (!rsp_valid_o || rsp_ready_i))
    else $error("result overwrites a waiting response");

endmodule

`default_nettype wire

// ===== verif/tb_spfa_shortest_path_negcycle.sv =====
// ----------------------------------------------------------------------------
// SPFA shortest path testbench
// Drives edge loads, graph clears and solves through the request channel. Its
// own shortest-path predictor mirrors the block's graph, and every response is
// checked against it under several dequeue-limit settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_spfa_shortest_path_negcycle;

  localparam int unsigned NODES = 1024;
  localparam int unsigned EDGES = 8192;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 100000000;
  localparam int unsigned SETTLE_CYCLES = 1200;

  typedef struct {
    logic [1:0]         func;
    logic [9:0]         from_node;
    logic [9:0]         to_node;
    logic signed [31:0] weight;
    logic [9:0]         source_node;
    logic [9:0]         target_node;
  } request_t;

  typedef struct {
    logic               negative_cycle;
    logic               unreachable;
    logic signed [31:0] distance;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  spfa_req_if req_if ();
  spfa_rsp_if rsp_if ();
  spfa_cfg_if cfg_if ();

  spfa_shortest_path_negcycle dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  request_t request_on_bus;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned req_gap = 0;
  bit no_idle = 1'b0;

  // Mirror of the graph and the solver work storage.
  logic [9:0]         edge_to[EDGES];
  logic [13:0]        edge_next[EDGES];
  logic signed [31:0] edge_weight[EDGES];
  logic [13:0]        first_edge[NODES];
  int unsigned        edges_held;
  logic [10:0]        pop_limit;
  logic signed [31:0] dist_of[NODES];
  bit                 seen[NODES];
  bit                 waiting[NODES];
  int unsigned        pops[NODES];
  logic [9:0]         fifo[NODES];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [31:0] add_saturated(logic signed [31:0] a,
                                                       logic signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  // Returns 1 when some node is dequeued as often as the limit allows.
  function automatic bit relax_from(logic [9:0] src);
    int unsigned limit, rd, wr, used, u, p, k, v;
    logic signed [31:0] nd;
    limit = (pop_limit == 0) ? 1 : pop_limit;
    for (int i = 0; i < NODES; i++) begin
      seen[i] = 0;
      waiting[i] = 0;
      pops[i] = 0;
      dist_of[i] = 0;
    end
    seen[src] = 1;
    waiting[src] = 1;
    fifo[0] = src;
    rd = 0;
    wr = 1;
    used = 1;
    while (used > 0) begin
      u = fifo[rd];
      rd = (rd + 1) % NODES;
      used--;
      if (pops[u] < 2047) pops[u]++;
      if (pops[u] == limit) return 1;
      waiting[u] = 0;
      p = first_edge[u];
      while (p != 0) begin
        k = p - 1;
        v = edge_to[k];
        nd = add_saturated(dist_of[u], edge_weight[k]);
        if (!seen[v] || nd < dist_of[v]) begin
          dist_of[v] = nd;
          seen[v] = 1;
          if (!waiting[v] && used < NODES) begin
            waiting[v] = 1;
            fifo[wr] = 10'(v);
            wr = (wr + 1) % NODES;
            used++;
          end
        end
        p = edge_next[k];
      end
    end
    return 0;
  endfunction

  function automatic void predict_request(request_t r);
    answer_t a;
    case (r.func)
      spfa_pkg::FUNC_ADD: begin
        if (edges_held < EDGES) begin
          edge_to[edges_held] = r.to_node;
          edge_weight[edges_held] = r.weight;
          edge_next[edges_held] = first_edge[r.from_node];
          first_edge[r.from_node] = 14'(edges_held + 1);
          edges_held++;
        end
      end
      spfa_pkg::FUNC_CLEAR: begin
        for (int i = 0; i < NODES; i++) first_edge[i] = '0;
        edges_held = 0;
      end
      spfa_pkg::FUNC_SOLVE: begin
        a = '{negative_cycle: 1'b0, unreachable: 1'b0, distance: 32'sd0};
        if (relax_from(r.source_node)) a.negative_cycle = 1'b1;
        else if (!seen[r.target_node]) a.unreachable = 1'b1;
        else a.distance = dist_of[r.target_node];
        expected_answers.push_back(a);
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) predict_request(request_on_bus);
      if (!req_if.valid || req_if.ready) begin
        if (req_gap > 0) begin
          req_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          request_on_bus = pending_requests.pop_front();
          req_if.valid <= 1'b1;
          req_if.func <= request_on_bus.func;
          req_if.from_node <= request_on_bus.from_node;
          req_if.to_node <= request_on_bus.to_node;
          req_if.weight <= request_on_bus.weight;
          req_if.source_node <= request_on_bus.source_node;
          req_if.target_node <= request_on_bus.target_node;
          req_gap = pick_gap();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("tb_spfa_shortest_path_negcycle: FAIL");
        $finish;
      end else begin
        if (rsp_if.valid && rsp_if.ready) begin
          if (expected_answers.size() == 0) begin
            $display("response with no solve outstanding");
            errors++;
          end else begin
            want = expected_answers.pop_front();
            if (rsp_if.negative_cycle !== want.negative_cycle)
              report("negative_cycle", rsp_if.negative_cycle, want.negative_cycle);
            if (rsp_if.unreachable !== want.unreachable)
              report("unreachable", rsp_if.unreachable, want.unreachable);
            if (rsp_if.distance !== want.distance)
              report("distance", rsp_if.distance, want.distance);
          end
        end
        rsp_if.ready <= no_idle ? 1'b1 : (pick_gap() == 0);
      end
    end
  end

  function automatic request_t make_request(logic [1:0] f, logic [9:0] a, logic [9:0] b,
                                            logic signed [31:0] w);
    request_t r;
    r.func = f;
    r.from_node = a;
    r.to_node = b;
    r.weight = w;
    r.source_node = a;
    r.target_node = b;
    if (f != spfa_pkg::FUNC_SOLVE) begin
      r.source_node = 10'($urandom);
      r.target_node = 10'($urandom);
    end
    if (f != spfa_pkg::FUNC_ADD) begin
      r.from_node = 10'($urandom);
      r.to_node = 10'($urandom);
      r.weight = $urandom;
    end
    return r;
  endfunction

  task automatic queue_request(logic [1:0] f, logic [9:0] a, logic [9:0] b,
                               logic signed [31:0] w);
    pending_requests.push_back(make_request(f, a, b, w));
  endtask

  // Small random graphs followed by solves; some noise requests in between.
  task automatic queue_random_graphs(int unsigned count, int unsigned neg_pct);
    int unsigned n, nodes, links, solves;
    logic [9:0] base;
    logic signed [31:0] w;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 99) < 10) begin
        queue_request($urandom_range(0, 99) < 50 ? FUNC_UNUSED : spfa_pkg::FUNC_ADD,
                      10'($urandom), 10'($urandom), $urandom);
        n++;
      end else begin
        queue_request(spfa_pkg::FUNC_CLEAR, 10'd0, 10'd0, 32'sd0);
        nodes = $urandom_range(2, 8);
        links = $urandom_range(nodes, 3 * nodes);
        base = 10'($urandom);
        for (int i = 0; i < links; i++) begin
          if ($urandom_range(0, 99) < 4) w = $urandom;
          else if ($urandom_range(0, 99) < neg_pct) w = -$urandom_range(0, 20);
          else w = $urandom_range(0, 50);
          queue_request(spfa_pkg::FUNC_ADD, 10'(base + $urandom_range(0, nodes - 1)),
                        10'(base + $urandom_range(0, nodes - 1)), w);
        end
        solves = $urandom_range(2, 4);
        for (int i = 0; i < solves; i++) begin
          if ($urandom_range(0, 9) == 0)
            queue_request(spfa_pkg::FUNC_SOLVE, 10'($urandom), 10'($urandom), 32'sd0);
          else
            queue_request(spfa_pkg::FUNC_SOLVE, 10'(base + $urandom_range(0, nodes - 1)),
                          10'(base + $urandom_range(0, nodes - 1)), 32'sd0);
        end
        n += 1 + links + solves;
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_requests.size() > 0 || req_if.valid || expected_answers.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_node_count(logic [10:0] value);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    pop_limit = value;
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.func = spfa_pkg::FUNC_ADD;
    req_if.from_node = '0;
    req_if.to_node = '0;
    req_if.weight = '0;
    req_if.source_node = '0;
    req_if.target_node = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    for (int i = 0; i < NODES; i++) first_edge[i] = '0;
    edges_held = 0;
    pop_limit = spfa_pkg::NODE_COUNT_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Saturation at both bounds, self distance, unreachable, negative cycle.
    queue_request(spfa_pkg::FUNC_ADD, 10'd0, 10'd1023, 32'sh7fffffff);
    queue_request(spfa_pkg::FUNC_ADD, 10'd1023, 10'd5, 32'sd100);
    queue_request(spfa_pkg::FUNC_SOLVE, 10'd0, 10'd5, 32'sd0);
    queue_request(spfa_pkg::FUNC_ADD, 10'd1, 10'd2, 32'sh80000000);
    queue_request(spfa_pkg::FUNC_ADD, 10'd2, 10'd3, -32'sd5);
    queue_request(spfa_pkg::FUNC_SOLVE, 10'd1, 10'd3, 32'sd0);
    queue_request(spfa_pkg::FUNC_SOLVE, 10'd0, 10'd0, 32'sd0);
    queue_request(spfa_pkg::FUNC_SOLVE, 10'd0, 10'd7, 32'sd0);
    queue_request(spfa_pkg::FUNC_ADD, 10'd3, 10'd4, 32'sd1);
    queue_request(spfa_pkg::FUNC_ADD, 10'd4, 10'd3, -32'sd2);
    queue_request(spfa_pkg::FUNC_SOLVE, 10'd3, 10'd3, 32'sd0);
    queue_request(spfa_pkg::FUNC_SOLVE, 10'd4, 10'd1023, 32'sd0);
    queue_request(FUNC_UNUSED, 10'd1023, 10'd1023, 32'sh7fffffff);
    queue_request(spfa_pkg::FUNC_ADD, 10'd0, 10'd0, 32'sd0);
    queue_request(spfa_pkg::FUNC_SOLVE, 10'd0, 10'd1023, 32'sd0);
    queue_request(spfa_pkg::FUNC_CLEAR, 10'd0, 10'd0, 32'sd0);
    queue_request(spfa_pkg::FUNC_SOLVE, 10'd0, 10'd5, 32'sd0);

    queue_random_graphs(350, 2);
    write_node_count(11'd0);
    queue_random_graphs(100, 30);
    write_node_count(11'd1);
    queue_random_graphs(100, 30);
    write_node_count(11'd2047);
    no_idle = 1'b1;
    queue_random_graphs(150, 3);
    wait_idle();
    no_idle = 1'b0;
    write_node_count(11'($urandom_range(2, 20)));
    queue_random_graphs(350, 30);
    wait_idle();

    if (errors == 0) begin
      $display("tb_spfa_shortest_path_negcycle: PASS");
    end else begin
      $display("tb_spfa_shortest_path_negcycle: FAIL");
    end
    $finish;
  end

endmodule
